/* hw/rtl/sllt_pkg.sv */
package sllt_pkg;

  // Line geometry
  localparam int LINE_LEN = 8;
  localparam int IDX_W    = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int CNT_W    = $clog2(LINE_LEN + 1);
  localparam int COL_W    = 4;
  localparam int PC_W     = 3;

  // Received byte codes
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Display command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PUT   = 2'd1;
  localparam logic [1:0] CMD_MOVE  = 2'd2;

  // Microprogram step addresses
  localparam logic [PC_W-1:0] PC_LF_CLR  = 3'd0;
  localparam logic [PC_W-1:0] PC_LF_PUT  = 3'd1;
  localparam logic [PC_W-1:0] PC_LF_MOV  = 3'd2;
  localparam logic [PC_W-1:0] PC_SC_HOME = 3'd3;
  localparam logic [PC_W-1:0] PC_CH_PUT  = 3'd4;
  localparam logic [PC_W-1:0] PC_FF_CLR  = 3'd5;
  localparam logic [PC_W-1:0] PC_CR_HOME = 3'd6;

  typedef enum logic [1:0] {
    CHR_ZERO,
    CHR_BUF,
    CHR_BYTE
  } chr_sel_t;

  typedef enum logic {
    COL_ONE,
    COL_CNT
  } col_sel_t;

  typedef enum logic [1:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_CNT_ZERO,
    BR_IDX_MORE
  } br_cond_t;

  typedef enum logic [1:0] {
    DONE_NEVER,
    DONE_ALWAYS,
    DONE_NO_SCROLL
  } done_cond_t;

  typedef struct packed {
    logic [1:0]      kind;
    chr_sel_t        chr_sel;
    col_sel_t        col_sel;
    logic            buf_clear;   // write space at idx, advance idx
    logic            cnt_clear;
    logic            store_inc;   // store byte at count, advance count
    br_cond_t        br_cond;
    logic [PC_W-1:0] br_target;
    done_cond_t      done_cond;
  } ctrl_word_t;

  // Control store: one word per sequencer step
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{kind: CMD_CLEAR, chr_sel: CHR_ZERO, col_sel: COL_ONE, buf_clear: 1'b0,
          cnt_clear: 1'b0, store_inc: 1'b0, br_cond: BR_NEVER,
          br_target: PC_LF_CLR, done_cond: DONE_ALWAYS};
    case (pc)
      PC_LF_CLR: begin
        w.kind      = CMD_CLEAR;
        w.br_cond   = BR_CNT_ZERO;
        w.br_target = PC_LF_MOV;
        w.done_cond = DONE_NEVER;
      end
      PC_LF_PUT: begin
        w.kind      = CMD_PUT;
        w.chr_sel   = CHR_BUF;
        w.buf_clear = 1'b1;
        w.br_cond   = BR_IDX_MORE;
        w.br_target = PC_LF_PUT;
        w.done_cond = DONE_NEVER;
      end
      PC_LF_MOV: begin
        w.kind      = CMD_MOVE;
        w.col_sel   = COL_CNT;
        w.done_cond = DONE_NO_SCROLL;
      end
      PC_SC_HOME: begin
        w.kind      = CMD_MOVE;
        w.cnt_clear = 1'b1;
        w.done_cond = DONE_NEVER;
      end
      PC_CH_PUT: begin
        w.kind      = CMD_PUT;
        w.chr_sel   = CHR_BYTE;
        w.store_inc = 1'b1;
        w.done_cond = DONE_ALWAYS;
      end
      PC_FF_CLR: begin
        w.kind      = CMD_CLEAR;
        w.done_cond = DONE_NEVER;
      end
      PC_CR_HOME: begin
        w.kind      = CMD_MOVE;
        w.cnt_clear = 1'b1;
        w.done_cond = DONE_ALWAYS;
      end
      default: begin
        w.done_cond = DONE_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/serial_to_lcd_line_terminal_unit.sv */
// Channel  Ports                                        Direction
// -------  -------------------------------------------  ---------
// input    in_valid, in_ready, in_rx_byte               in
// result   out_valid, out_ready, out_cmd_kind,          out
//          out_char_code, out_cursor_col, out_last
//
// One received byte produces 1 to 12 display commands, one per sequencer step;
// a byte keeps the block busy, with in_ready low, until its final command has
// been issued, so a new byte is not taken meanwhile.
// The loop over the line buffer is a single microcode step that repeats.
// A step waits while the output register holds an item not yet taken.
// Reset clears the column count and control; the line buffer is not cleared.
module serial_to_lcd_line_terminal_unit
  import sllt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_cmd_kind,
  output logic [7:0]       out_char_code,
  output logic [COL_W-1:0] out_cursor_col,
  output logic             out_last
);

  logic             busy_r, busy_nxt;
  logic             scroll_r, scroll_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       byte_r;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_char_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;
  logic [7:0]       buf_r [LINE_LEN];

  ctrl_word_t       cw;
  logic             in_fire;
  logic             step_go;
  logic             done;
  logic             br_take;
  logic [7:0]       chr_val;
  logic [COL_W-1:0] col_val;

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign step_go  = busy_r && (!out_valid_r || out_ready);
  assign cw       = ucode_rom(pc_r);

  // Evaluate branch and end conditions of the current word
  always_comb begin
    case (cw.br_cond)
      BR_ALWAYS:   br_take = 1'b1;
      BR_CNT_ZERO: br_take = (cnt_r == '0);
      BR_IDX_MORE: br_take = ((CNT_W'(idx_r) + CNT_W'(1)) < cnt_r);
      default:     br_take = 1'b0;
    endcase
    case (cw.done_cond)
      DONE_ALWAYS:    done = 1'b1;
      DONE_NO_SCROLL: done = !scroll_r;
      default:        done = 1'b0;
    endcase
  end

  // Select command payload
  always_comb begin
    case (cw.chr_sel)
      CHR_BUF:  chr_val = buf_r[idx_r];
      CHR_BYTE: chr_val = byte_r;
      default:  chr_val = 8'd0;
    endcase
    case (cw.col_sel)
      COL_CNT: col_val = COL_W'(cnt_r + CNT_W'(1));
      default: col_val = COL_W'(1);
    endcase
  end

  // Sequencer next state
  always_comb begin
    busy_nxt      = busy_r;
    scroll_nxt    = scroll_r;
    pc_nxt        = pc_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      busy_nxt   = 1'b1;
      idx_nxt    = '0;
      scroll_nxt = 1'b0;
      case (in_rx_byte)
        CH_LF:   pc_nxt = PC_LF_CLR;
        CH_CR:   pc_nxt = PC_CR_HOME;
        CH_FF:   pc_nxt = PC_FF_CLR;
        default: begin
          if (cnt_r >= CNT_W'(LINE_LEN)) begin
            pc_nxt     = PC_LF_CLR;
            scroll_nxt = 1'b1;
          end else begin
            pc_nxt = PC_CH_PUT;
          end
        end
      endcase
    end else if (step_go) begin
      out_valid_nxt = 1'b1;
      if (cw.buf_clear) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (cw.cnt_clear) begin
        cnt_nxt = '0;
      end else if (cw.store_inc) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (done) begin
        busy_nxt = 1'b0;
      end else if (br_take) begin
        pc_nxt = cw.br_target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      scroll_r    <= 1'b0;
      pc_r        <= PC_LF_CLR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      scroll_r    <= scroll_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers and line buffer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_rx_byte;
    end
    if (step_go) begin
      out_kind_r <= cw.kind;
      out_char_r <= chr_val;
      out_col_r  <= col_val;
      out_last_r <= done;
      if (cw.buf_clear) begin
        buf_r[idx_r] <= CH_SPACE;
      end
      if (cw.store_inc) begin
        buf_r[cnt_r[IDX_W-1:0]] <= byte_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cmd_kind   = out_kind_r;
  assign out_char_code  = out_char_r;
  assign out_cursor_col = out_col_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  // Count never runs past a full line
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LINE_LEN))
    else $error("column count beyond line length");

  // Final step of a byte frees the sequencer
  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && done |=> !busy_r && out_valid_r && out_last_r)
    else $error("sequencer still busy after final command");

  // An accepted byte starts a command sequence
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r)
    else $error("accepted byte did not start sequencer");

  // Buffer loop stays inside the line
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pc_r == PC_LF_PUT |-> CNT_W'(idx_r) < cnt_r)
    else $error("buffer index past column count");
`endif

endmodule

/* tb/serial_to_lcd_line_terminal_unit_tb.sv */
module serial_to_lcd_line_terminal_unit_tb;
  import sllt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 480;

  typedef struct {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [COL_W-1:0] cursor_col;
    logic             last;
  } display_cmd_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_rx_byte = 8'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_cmd_kind;
  logic [7:0]       out_char_code;
  logic [COL_W-1:0] out_cursor_col;
  logic             out_last;

  // Shadow of the terminal state
  logic [7:0]       line_shadow [LINE_LEN];
  logic [COL_W-1:0] col_shadow;

  logic [7:0]   rx_stream [$];
  display_cmd_t pending_cmds [$];
  int unsigned  bytes_total;
  int unsigned  bytes_taken;
  int unsigned  burst_left;
  int unsigned  gap_left;
  int unsigned  stall_mode;
  int unsigned  mode_left;
  int unsigned  cycle_count;
  int unsigned  errors;

  serial_to_lcd_line_terminal_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cmd_kind   (out_cmd_kind),
    .out_char_code  (out_char_code),
    .out_cursor_col (out_cursor_col),
    .out_last       (out_last)
  );

  always #10 clk = ~clk;

  function automatic void queue_cmd(logic [1:0] kind, logic [7:0] ch, logic [COL_W-1:0] col);
    display_cmd_t c;
    c.kind       = kind;
    c.char_code  = ch;
    c.cursor_col = col;
    c.last       = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  // Clear, reprint the line on line 1, blank the buffer, park the cursor on line 2
  function automatic void queue_line_feed();
    for (int i = 0; i < LINE_LEN; i++) begin
      if (i >= col_shadow) break;
      if (i == 0) queue_cmd(CMD_CLEAR, 8'd0, COL_W'(1));
      queue_cmd(CMD_PUT, line_shadow[i], COL_W'(1));
      line_shadow[i] = CH_SPACE;
    end
    if (col_shadow == 0) queue_cmd(CMD_CLEAR, 8'd0, COL_W'(1));
    queue_cmd(CMD_MOVE, 8'd0, col_shadow + 1'b1);
  endfunction

  function automatic void predict_display_cmds(logic [7:0] rx);
    display_cmd_t tail;
    if (rx == CH_LF) begin
      queue_line_feed();
    end else if (rx == CH_CR) begin
      queue_cmd(CMD_MOVE, 8'd0, COL_W'(1));
      col_shadow = '0;
    end else if (rx == CH_FF) begin
      queue_cmd(CMD_CLEAR, 8'd0, COL_W'(1));
      queue_cmd(CMD_MOVE, 8'd0, COL_W'(1));
      col_shadow = '0;
    end else begin
      // Scroll a full line before printing
      if (col_shadow > LINE_LEN - 1) begin
        queue_line_feed();
        queue_cmd(CMD_MOVE, 8'd0, COL_W'(1));
        col_shadow = '0;
      end
      queue_cmd(CMD_PUT, rx, COL_W'(1));
      if (col_shadow < LINE_LEN) line_shadow[col_shadow[IDX_W-1:0]] = rx;
      col_shadow = col_shadow + 1'b1;
    end
    tail = pending_cmds.pop_back();
    tail.last = 1'b1;
    pending_cmds.push_back(tail);
  endfunction

  // Pick the next burst and gap; now and then a long burst with no gap
  function automatic void pick_burst();
    if ($urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(20, 60);
      gap_left   = 0;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap_left   = $urandom_range(0, 15);
    end
  endfunction

  // Sender: hold each item until taken, idle between bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_display_cmds(in_rx_byte);
        bytes_taken++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) pick_burst();
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || rx_stream.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_stream.pop_front();
        end
      end
    end
  end

  // Receiver: check each command, stall on a changing pattern
  always @(posedge clk) begin
    display_cmd_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t: unexpected command kind %0d char %0d col %0d last %0d", $time,
                   out_cmd_kind, out_char_code, out_cursor_col, out_last);
          errors++;
        end else begin
          want = pending_cmds.pop_front();
          if (out_cmd_kind !== want.kind) begin
            $display("%0t: cmd_kind expected %0d actual %0d", $time, want.kind, out_cmd_kind);
            errors++;
          end
          if (out_char_code !== want.char_code) begin
            $display("%0t: char_code expected %0d actual %0d", $time, want.char_code,
                     out_char_code);
            errors++;
          end
          if (out_cursor_col !== want.cursor_col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time, want.cursor_col,
                     out_cursor_col);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(40, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= (cycle_count[2:0] != 3'd5) && (cycle_count[2:0] != 3'd6);
        end
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned run;
    logic [7:0] directed [] = '{
      CH_LF, CH_CR, CH_FF, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h09, 8'h0B, 8'h0E,
      CH_SPACE, CH_LF, 8'h41, 8'h42, CH_LF, CH_CR, 8'h43, CH_FF, 8'h44, CH_CR,
      CH_LF, 8'h55, 8'hAA
    };
    errors      = 0;
    bytes_taken = 0;
    cycle_count = 0;
    mode_left   = 0;
    stall_mode  = 0;
    col_shadow  = '0;
    pick_burst();

    foreach (directed[i]) rx_stream.push_back(directed[i]);

    // Mostly lines of random bytes with a terminator, the rest with none
    n = 0;
    while (n < RANDOM_ITEMS) begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 9);
      for (int i = 0; i < run; i++) rx_stream.push_back(8'($urandom_range(0, 255)));
      n += run;
      case ($urandom_range(0, 7))
        0, 1: begin
          rx_stream.push_back(CH_LF);
          n++;
        end
        2: begin
          rx_stream.push_back(CH_CR);
          n++;
        end
        3: begin
          rx_stream.push_back(CH_CR);
          rx_stream.push_back(CH_LF);
          n += 2;
        end
        4: begin
          rx_stream.push_back(CH_LF);
          rx_stream.push_back(CH_CR);
          n += 2;
        end
        5: begin
          rx_stream.push_back(CH_FF);
          n++;
        end
        default: begin
        end
      endcase
    end
    bytes_total = rx_stream.size();

    // Hold reset, then release
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < bytes_total || pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sllt_pkg.sv
hw/rtl/serial_to_lcd_line_terminal_unit.sv
tb/serial_to_lcd_line_terminal_unit_tb.sv
